### sv/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants of the accelerometer step counter.
// ----------------------------------------------------------------------------
package asc_pkg;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_RISE_MIN = 2'd0;
	localparam logic [1:0] REG_RISE_MAX = 2'd1;
	localparam logic [1:0] REG_GAP_MIN  = 2'd2;
	localparam logic [1:0] REG_GAP_MAX  = 2'd3;

	// register reset values
	localparam logic [15:0] RISE_MIN_RST = 16'd2000;
	localparam logic [15:0] RISE_MAX_RST = 16'd8000;
	localparam logic [15:0] GAP_MIN_RST  = 16'd200;
	localparam logic [15:0] GAP_MAX_RST  = 16'd2000;

	// opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// default depth of the queue between front and back (2 or more)
	localparam int ASC_QDEPTH = 2;

	typedef struct packed {
		logic [15:0] rise_min;
		logic [15:0] rise_max;
		logic [15:0] gap_min;
		logic [15:0] gap_max;
	} asc_cfg_t;

	// queued work: opcode, sum of squares, timestamp
	typedef struct packed {
		logic        op;
		logic [31:0] sum;
		logic [31:0] time_ms;
	} asc_item_t;

endpackage

### sv/accel_step_counter.sv
// ----------------------------------------------------------------------------
// accel_step_counter
// Pedometer step detection on timestamped three-axis accelerometer samples.
//
//   port group   dir  payload
//   s_*          in   tuser: opcode; tdata: accel_x, accel_y, accel_z, time_ms
//   m_*          out  tuser: step_found; tdata: total_steps, today_steps
//   APB          in   rise_min 0x0, rise_max 0x4, gap_min_ms 0x8, gap_max_ms 0xC
//
// A sample passes the back part as queue read, the bit-serial square root
// (16 result bits, then done), compares and count update. The front squares
// the axes one after another, overlapped with the back via the queue. A clear
// takes only the queue read and the count update in the back part.
// Reset is immediate, no sweep.
// A held result stalls the back part; the front goes on until the queue is full.
// ----------------------------------------------------------------------------
module accel_step_counter import asc_pkg::*; #(
	parameter int QDepth = ASC_QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // [0] opcode
	input  logic [79:0] s_tdata,   // accel_x, accel_y, accel_z, time_ms
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,   // [0] step_found
	output logic [63:0] m_tdata,   // total_steps, today_steps
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	asc_cfg_t  cfg_q;
	logic      wr_en;
	logic      push, pop, q_full, q_empty;
	asc_item_t push_item, pop_item;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_min <= RISE_MIN_RST;
			cfg_q.rise_max <= RISE_MAX_RST;
			cfg_q.gap_min  <= GAP_MIN_RST;
			cfg_q.gap_max  <= GAP_MAX_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_RISE_MIN: cfg_q.rise_min <= pwdata[15:0];
				REG_RISE_MAX: cfg_q.rise_max <= pwdata[15:0];
				REG_GAP_MIN:  cfg_q.gap_min  <= pwdata[15:0];
				REG_GAP_MAX:  cfg_q.gap_max  <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RISE_MIN: prdata = {16'd0, cfg_q.rise_min};
			REG_RISE_MAX: prdata = {16'd0, cfg_q.rise_max};
			REG_GAP_MIN:  prdata = {16'd0, cfg_q.gap_min};
			REG_GAP_MAX:  prdata = {16'd0, cfg_q.gap_max};
			default:      prdata = '0;
		endcase
	end

	asc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	asc_fifo #(.Depth(QDepth)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	asc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule

### sv/asc_front.sv
// ----------------------------------------------------------------------------
// asc_front
// Accepts items, squares a sample's three axes with one shared multiplier and
// queues the sum of squares with the opcode and timestamp.
// ----------------------------------------------------------------------------
module asc_front import asc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             s_tuser,   // opcode
	input  logic [79:0]      s_tdata,   // accel_x, accel_y, accel_z, time_ms
	output logic             push,
	output asc_item_t        push_item,
	input  logic             q_full
);

	typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} fstate_t;

	localparam logic [1:0] AXIS_X   = 2'd0;
	localparam logic [1:0] AXIS_Y   = 2'd1;
	localparam logic [1:0] AXIS_Z   = 2'd2;
	localparam logic [1:0] AXIS_ACC = 2'd3;

	fstate_t            state_q;
	logic [1:0]         axis_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic               op_q;
	logic [31:0]        time_q;
	logic [30:0]        prod_q;
	logic [31:0]        acc_q;
	logic signed [15:0] sel;
	logic signed [31:0] sq;

	always_comb begin
		case (axis_q)
			AXIS_X:  sel = ax_q;
			AXIS_Y:  sel = ay_q;
			default: sel = az_q;
		endcase
	end

	assign sq = sel * sel;

	// product of one axis is registered and added in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						op_q   <= s_tuser;
						ax_q   <= s_tdata[15:0];
						ay_q   <= s_tdata[31:16];
						az_q   <= s_tdata[47:32];
						time_q <= s_tdata[79:48];
						acc_q  <= '0;
						axis_q <= AXIS_X;
						state_q <= (s_tuser == OP_CLEAR) ? F_PUSH : F_SQ;
					end
				end
				F_SQ: begin
					prod_q <= sq[30:0];
					if (axis_q != AXIS_X)
						acc_q <= acc_q + {1'b0, prod_q};
					if (axis_q == AXIS_ACC)
						state_q <= F_PUSH;
					else
						axis_q <= axis_q + 2'd1;
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign s_tready  = (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH) && !q_full;
	assign push_item = '{op: op_q, sum: acc_q, time_ms: time_q};

endmodule

### sv/asc_fifo.sv
// ----------------------------------------------------------------------------
// asc_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module asc_fifo import asc_pkg::*; #(
	parameter int Depth = ASC_QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  asc_item_t push_item,
	input  logic      pop,
	output asc_item_t pop_item,
	output logic      full,
	output logic      empty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	asc_item_t       mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign pop_item = mem_q[rd_ptr_q];
	assign full     = (count_q == DepthCnt);
	assign empty    = (count_q == '0);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

### sv/asc_isqrt.sv
// ----------------------------------------------------------------------------
// asc_isqrt
// Floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module asc_isqrt import asc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);

	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [17:0] rem_sh;
	logic [17:0] trial;
	logic        fits;

	assign rem_sh = {rem_q[15:0], rad_q[31:30]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'd16;
			end else if (cnt_q != '0) begin
				rad_q  <= {rad_q[29:0], 2'b00};
				rem_q  <= fits ? rem_sh - trial : rem_sh;
				root_q <= {root_q[14:0], fits};
				cnt_q  <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### sv/asc_back.sv
// ----------------------------------------------------------------------------
// asc_back
// Takes queued work, forms the magnitude, applies the step rules, keeps the
// step counters and holds the result register.
// ----------------------------------------------------------------------------
module asc_back import asc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  asc_cfg_t    cfg,
	input  logic        q_empty,
	input  asc_item_t   q_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,   // step_found
	output logic [63:0] m_tdata    // total_steps, today_steps
);

	typedef enum logic [1:0] {B_IDLE, B_ROOT, B_EVAL, B_DONE} bstate_t;

	bstate_t     state_q;
	logic        op_q;
	logic [31:0] time_q;
	logic [16:0] mag_q;
	logic [16:0] prev_q;
	logic [31:0] last_q;
	logic [31:0] total_q, today_q;
	logic        band_q, gap_ok_q, gap_over_q;
	logic        out_valid_q, out_found_q;
	logic [31:0] out_total_q, out_today_q;

	logic        sq_start, sq_done;
	logic [15:0] sq_root;
	logic [16:0] rise;
	logic [31:0] gap;
	logic        out_free, load, step_now;
	logic [31:0] total_n, today_n;

	asc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (q_item.sum),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign sq_start = pop && (q_item.op == OP_SAMPLE);

	assign rise     = mag_q - prev_q;
	assign gap      = time_q - last_q;
	assign out_free = !out_valid_q || m_tready;
	assign load     = (state_q == B_DONE) && out_free;
	assign step_now = (op_q == OP_SAMPLE) && band_q && gap_ok_q;

	always_comb begin
		total_n = total_q;
		today_n = today_q;
		if (op_q == OP_CLEAR) begin
			today_n = '0;
		end else if (step_now) begin
			total_n = total_q + 32'd1;
			today_n = today_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			prev_q      <= '0;
			last_q      <= '0;
			total_q     <= '0;
			today_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready && !load)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						op_q    <= q_item.op;
						time_q  <= q_item.time_ms;
						state_q <= (q_item.op == OP_CLEAR) ? B_DONE : B_ROOT;
					end
				end
				B_ROOT: begin
					if (sq_done) begin
						mag_q   <= {1'b0, sq_root};
						state_q <= B_EVAL;
					end
				end
				B_EVAL: begin
					// a zero previous magnitude only primes
					band_q     <= (prev_q != '0) && (mag_q > prev_q) &&
					              (rise > {1'b0, cfg.rise_min}) &&
					              (rise < {1'b0, cfg.rise_max});
					gap_ok_q   <= (gap > {16'd0, cfg.gap_min}) &&
					              (gap < {16'd0, cfg.gap_max});
					gap_over_q <= (gap >= {16'd0, cfg.gap_max});
					state_q    <= B_DONE;
				end
				B_DONE: begin
					if (out_free) begin
						total_q <= total_n;
						today_q <= today_n;
						if (op_q == OP_SAMPLE) begin
							prev_q <= mag_q;
							// lock-up repair: a stale gap restarts the window
							if (band_q && (gap_ok_q || gap_over_q))
								last_q <= time_q;
						end
						out_valid_q <= 1'b1;
						out_found_q <= step_now;
						out_total_q <= total_n;
						out_today_q <= today_n;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {out_today_q, out_total_q};

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid || m_tready)) else $error("result overwritten");
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load && step_now) |=> (total_q == $past(total_q) + 32'd1))
		else $error("step without count");
	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ROOT) |-> !pop) else $error("pop during root");
`endif

endmodule
